// File: src/huffman_code_builder_top_defines.svh
// Assertion macros shared by the checker.
`ifndef HUFFMAN_CODE_BUILDER_TOP_DEFINES_SVH
`define HUFFMAN_CODE_BUILDER_TOP_DEFINES_SVH

// Check a property outside reset.
`define HCB_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every edge, reset included.
`define HCB_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: src/hcb_pkg.sv
package hcb_pkg;

  localparam int WW = 32;

  typedef struct packed {
    logic        req_type;
    logic [7:0]  symbol_index;
    logic [23:0] symbol_weight;
    logic        last_weight;
  } in_word_t;

  typedef struct packed {
    logic [31:0] code_bits;
    logic [5:0]  code_length;
    logic [23:0] entry_weight;
    logic [1:0]  build_status;
  } out_word_t;

  typedef struct packed {
    logic [WW-1:0] sum;
    logic          gt;
    logic          lt;
  } alu_res_t;

  localparam logic        REQ_LOAD    = 1'b0;
  localparam logic [1:0]  STAT_OK     = 2'd0;
  localparam logic [1:0]  STAT_EMPTY  = 2'd1;
  localparam logic [1:0]  STAT_LONG   = 2'd2;

endpackage

// File: src/huffman_code_builder_top.sv
// Huffman code table builder.
// Input channel in_valid/in_ready/in_data carries request words. A load word
// writes one symbol weight as it is taken; a load with last_weight set then
// starts a tree build. A read word returns one result word on the out_
// channel holding the code, its length, the weight and the build status.
// out_valid rises once the read has passed the RWAIT state and the output
// register is free; a read holds in_ready low while in RWAIT, so no further
// request is taken until its result word is loaded into the output register.
// Build steps: a clear of the code table, a leaf pass with insertion sort
// of each present symbol into the order list, then per merge a pass over
// the entries still in the active list, then a tree walk over the nodes.
// The order list memory has one read port, which paces these passes.
// in_ready is low during the build.
// After reset the weight table is cleared with in_ready low. When the
// receiver stalls, the result word is held in the output register; loads
// are still taken meanwhile, a further read is taken but then holds
// in_ready low until the held word leaves.
module huffman_code_builder_top
  import hcb_pkg::*;
#(
  parameter int NUM_SYMBOLS  = 256,
  parameter int MAX_CODE_LEN = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_word_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_word_t out_data
);

  localparam int SW   = $clog2(NUM_SYMBOLS);
  localparam int ND   = 2 * NUM_SYMBOLS - 1;
  localparam int NW   = $clog2(ND);
  localparam int NIW  = 1 + 2 * NW + 24;
  localparam int PW   = NW + WW;
  localparam int AEW  = NW + WW;
  localparam int CW   = 32 + 6 + 24;

  localparam logic [4:0] ST_RCLR  = 5'd0;
  localparam logic [4:0] ST_IDLE  = 5'd1;
  localparam logic [4:0] ST_RWAIT = 5'd2;
  localparam logic [4:0] ST_BCLR  = 5'd3;
  localparam logic [4:0] ST_LRD   = 5'd4;
  localparam logic [4:0] ST_LCHK  = 5'd5;
  localparam logic [4:0] ST_IRD   = 5'd6;
  localparam logic [4:0] ST_ICHK  = 5'd7;
  localparam logic [4:0] ST_LNEXT = 5'd8;
  localparam logic [4:0] ST_MA    = 5'd9;
  localparam logic [4:0] ST_MB    = 5'd10;
  localparam logic [4:0] ST_MC    = 5'd11;
  localparam logic [4:0] ST_PRD   = 5'd12;
  localparam logic [4:0] ST_PEX   = 5'd13;
  localparam logic [4:0] ST_PEX2  = 5'd14;
  localparam logic [4:0] ST_PEND  = 5'd15;
  localparam logic [4:0] ST_WINIT = 5'd16;
  localparam logic [4:0] ST_WRD   = 5'd17;
  localparam logic [4:0] ST_WEX   = 5'd18;
  localparam logic [4:0] ST_WEX2  = 5'd19;

  logic [4:0]    state_r, state_nxt;
  logic [SW-1:0] s_r, s_nxt;
  logic [SW:0]   count_r, count_nxt;
  logic [NW-1:0] nodes_r, nodes_nxt;
  logic [SW-1:0] pos_r, pos_nxt;
  logic [SW-1:0] i_r, i_nxt;
  logic [SW-1:0] o_r, o_nxt;
  logic          ins_r, ins_nxt;
  logic [NW-1:0] n_r, n_nxt;
  logic [WW-1:0] cur_w_r, cur_w_nxt;
  logic [AEW-1:0] a_r, a_nxt;
  logic [AEW-1:0] e_r, e_nxt;
  logic [1:0]    status_r, status_nxt;
  logic [SW-1:0] rd_sym_r, rd_sym_nxt;
  logic          oor_r, oor_nxt;
  logic          out_valid_r, out_valid_nxt;
  out_word_t     out_data_r, out_data_nxt;

  // memory ports
  logic          w_we;
  logic [SW-1:0] w_waddr, w_raddr;
  logic [23:0]   w_wdata, w_rdata;
  logic          c_we;
  logic [SW-1:0] c_waddr, c_raddr;
  logic [CW-1:0] c_wdata, c_rdata;
  logic          a_we;
  logic [SW-1:0] a_waddr, a_raddr;
  logic [AEW-1:0] a_wdata, a_rdata;
  logic          ni_we;
  logic [NW-1:0] ni_waddr, ni_raddr;
  logic [NIW-1:0] ni_wdata, ni_rdata;
  logic          p_we;
  logic [NW-1:0] p_waddr, p_raddr;
  logic [PW-1:0] p_wdata, p_rdata;

  logic [WW-1:0] alu_x, alu_y;
  alu_res_t      alu_res;

  logic [SW-1:0] in_idx;
  logic          in_oor;
  logic [AEW-1:0] new_ent;
  logic [AEW-1:0] ins_ent;
  logic          leaf_f;
  logic [NW-1:0] left_f, right_f;
  logic [23:0]   lwt_f;
  logic [NW-1:0] depth_f;
  logic [WW-1:0] code_f;

  hc_ram #(.WIDTH(24), .DEPTH(NUM_SYMBOLS)) u_weight (
    .clk(clk), .we(w_we), .waddr(w_waddr), .wdata(w_wdata),
    .raddr(w_raddr), .rdata(w_rdata));
  hc_ram #(.WIDTH(CW), .DEPTH(NUM_SYMBOLS)) u_code (
    .clk(clk), .we(c_we), .waddr(c_waddr), .wdata(c_wdata),
    .raddr(c_raddr), .rdata(c_rdata));
  hc_ram #(.WIDTH(AEW), .DEPTH(NUM_SYMBOLS)) u_order (
    .clk(clk), .we(a_we), .waddr(a_waddr), .wdata(a_wdata),
    .raddr(a_raddr), .rdata(a_rdata));
  hc_ram #(.WIDTH(NIW), .DEPTH(ND)) u_node (
    .clk(clk), .we(ni_we), .waddr(ni_waddr), .wdata(ni_wdata),
    .raddr(ni_raddr), .rdata(ni_rdata));
  hc_ram #(.WIDTH(PW), .DEPTH(ND)) u_path (
    .clk(clk), .we(p_we), .waddr(p_waddr), .wdata(p_wdata),
    .raddr(p_raddr), .rdata(p_rdata));

  hc_alu u_alu (.x(alu_x), .y(alu_y), .res(alu_res));

  assign in_idx  = SW'(in_data.symbol_index);
  assign in_oor  = (int'(in_data.symbol_index) >= NUM_SYMBOLS);
  assign new_ent = {nodes_r, cur_w_r};
  assign {leaf_f, left_f, right_f, lwt_f} = ni_rdata;
  assign {depth_f, code_f} = p_rdata;

  // order list entry that goes into the insertion pass: the new parent
  assign ins_ent = {nodes_r, cur_w_r};

  always_comb begin
    state_nxt     = state_r;
    s_nxt         = s_r;
    count_nxt     = count_r;
    nodes_nxt     = nodes_r;
    pos_nxt       = pos_r;
    i_nxt         = i_r;
    o_nxt         = o_r;
    ins_nxt       = ins_r;
    n_nxt         = n_r;
    cur_w_nxt     = cur_w_r;
    a_nxt         = a_r;
    e_nxt         = e_r;
    status_nxt    = status_r;
    rd_sym_nxt    = rd_sym_r;
    oor_nxt       = oor_r;
    out_valid_nxt = out_valid_r & ~out_ready;
    out_data_nxt  = out_data_r;

    w_we = 1'b0; w_waddr = s_r; w_wdata = '0; w_raddr = s_r;
    c_we = 1'b0; c_waddr = s_r; c_wdata = '0;
    c_raddr = (state_r == ST_IDLE) ? in_idx : rd_sym_r;
    a_we = 1'b0; a_waddr = o_r; a_wdata = '0; a_raddr = i_r;
    ni_we = 1'b0; ni_waddr = nodes_r; ni_wdata = '0; ni_raddr = n_r;
    p_we = 1'b0; p_waddr = left_f; p_wdata = '0; p_raddr = n_r;
    alu_x = a_rdata[WW-1:0];
    alu_y = cur_w_r;

    case (state_r)
      ST_RCLR: begin
        // zero the weight table
        w_we = 1'b1;
        if (s_r == '0) begin
          state_nxt = ST_IDLE;
        end else begin
          s_nxt = s_r - 1'b1;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          if (in_data.req_type == REQ_LOAD) begin
            w_we    = !in_oor;
            w_waddr = in_idx;
            w_wdata = in_data.symbol_weight;
            if (in_data.last_weight) begin
              s_nxt     = SW'(NUM_SYMBOLS - 1);
              state_nxt = ST_BCLR;
            end
          end else begin
            rd_sym_nxt = in_idx;
            oor_nxt    = in_oor;
            state_nxt  = ST_RWAIT;
          end
        end
      end
      ST_RWAIT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          if (oor_r) begin
            out_data_nxt = '{code_bits: '0, code_length: '0, entry_weight: '0,
                             build_status: status_r};
          end else begin
            out_data_nxt = {c_rdata, status_r};
          end
          state_nxt = ST_IDLE;
        end
      end
      ST_BCLR: begin
        c_we = 1'b1;
        if (s_r == '0) begin
          s_nxt     = SW'(NUM_SYMBOLS - 1);
          count_nxt = '0;
          nodes_nxt = '0;
          state_nxt = ST_LRD;
        end else begin
          s_nxt = s_r - 1'b1;
        end
      end
      ST_LRD: begin
        state_nxt = ST_LCHK;
      end
      ST_LCHK: begin
        if (w_rdata == '0) begin
          state_nxt = ST_LNEXT;
        end else begin
          ni_we     = 1'b1;
          ni_wdata  = {1'b1, NW'(s_r), NW'(0), w_rdata};
          cur_w_nxt = WW'(w_rdata);
          pos_nxt   = SW'(count_r);
          state_nxt = ST_IRD;
        end
      end
      ST_IRD: begin
        a_raddr = pos_r - 1'b1;
        if (pos_r == '0) begin
          a_we      = 1'b1;
          a_waddr   = pos_r;
          a_wdata   = new_ent;
          count_nxt = count_r + 1'b1;
          nodes_nxt = nodes_r + 1'b1;
          state_nxt = ST_LNEXT;
        end else begin
          state_nxt = ST_ICHK;
        end
      end
      ST_ICHK: begin
        // shift heavier entries up, stop at the first one not heavier
        a_raddr = pos_r - 1'b1;
        a_we    = 1'b1;
        a_waddr = pos_r;
        if (alu_res.gt) begin
          a_wdata   = a_rdata;
          pos_nxt   = pos_r - 1'b1;
          state_nxt = ST_IRD;
        end else begin
          a_wdata   = new_ent;
          count_nxt = count_r + 1'b1;
          nodes_nxt = nodes_r + 1'b1;
          state_nxt = ST_LNEXT;
        end
      end
      ST_LNEXT: begin
        if (s_r != '0) begin
          s_nxt     = s_r - 1'b1;
          state_nxt = ST_LRD;
        end else if (count_r == '0) begin
          status_nxt = STAT_EMPTY;
          state_nxt  = ST_IDLE;
        end else begin
          status_nxt = STAT_OK;
          state_nxt  = (count_r == (SW+1)'(1)) ? ST_WINIT : ST_MA;
        end
      end
      ST_MA: begin
        a_raddr   = '0;
        state_nxt = ST_MB;
      end
      ST_MB: begin
        a_raddr   = SW'(1);
        a_nxt     = a_rdata;
        state_nxt = ST_MC;
      end
      ST_MC: begin
        // lighter child goes left, ties keep the front entry on the left
        a_raddr   = SW'(1);
        alu_x     = a_r[WW-1:0];
        alu_y     = a_rdata[WW-1:0];
        cur_w_nxt = alu_res.sum;
        ni_we     = 1'b1;
        if (alu_res.gt) begin
          ni_wdata = {1'b0, a_rdata[AEW-1:WW], a_r[AEW-1:WW], 24'd0};
        end else begin
          ni_wdata = {1'b0, a_r[AEW-1:WW], a_rdata[AEW-1:WW], 24'd0};
        end
        i_nxt     = SW'(2);
        o_nxt     = '0;
        ins_nxt   = 1'b0;
        state_nxt = (count_r == (SW+1)'(2)) ? ST_PEND : ST_PRD;
      end
      ST_PRD: begin
        state_nxt = ST_PEX;
      end
      ST_PEX: begin
        alu_x = a_rdata[WW-1:0];
        alu_y = cur_w_r;
        a_we  = 1'b1;
        o_nxt = o_r + 1'b1;
        if (!ins_r && !alu_res.lt) begin
          a_wdata   = ins_ent;
          ins_nxt   = 1'b1;
          e_nxt     = a_rdata;
          state_nxt = ST_PEX2;
        end else begin
          a_wdata = a_rdata;
          if ((SW+1)'(i_r) == count_r - 1'b1) begin
            state_nxt = ST_PEND;
          end else begin
            i_nxt     = i_r + 1'b1;
            state_nxt = ST_PRD;
          end
        end
      end
      ST_PEX2: begin
        a_we    = 1'b1;
        a_wdata = e_r;
        o_nxt   = o_r + 1'b1;
        if ((SW+1)'(i_r) == count_r - 1'b1) begin
          state_nxt = ST_PEND;
        end else begin
          i_nxt     = i_r + 1'b1;
          state_nxt = ST_PRD;
        end
      end
      ST_PEND: begin
        a_we      = !ins_r;
        a_wdata   = ins_ent;
        count_nxt = count_r - 1'b1;
        nodes_nxt = nodes_r + 1'b1;
        state_nxt = (count_r == (SW+1)'(2)) ? ST_WINIT : ST_MA;
      end
      ST_WINIT: begin
        p_we      = 1'b1;
        p_waddr   = nodes_r - 1'b1;
        p_wdata   = '0;
        n_nxt     = nodes_r - 1'b1;
        state_nxt = ST_WRD;
      end
      ST_WRD: begin
        state_nxt = ST_WEX;
      end
      ST_WEX: begin
        if (leaf_f) begin
          c_we    = 1'b1;
          c_waddr = SW'(left_f);
          if (32'(depth_f) > 32'(MAX_CODE_LEN)) begin
            status_nxt = STAT_LONG;
            c_wdata    = {32'd0, 6'd0, lwt_f};
          end else begin
            c_wdata = {code_f, 6'(depth_f), lwt_f};
          end
          if (n_r == '0) begin
            state_nxt = ST_IDLE;
          end else begin
            n_nxt     = n_r - 1'b1;
            state_nxt = ST_WRD;
          end
        end else begin
          p_we      = 1'b1;
          p_waddr   = left_f;
          p_wdata   = {depth_f + 1'b1, code_f << 1};
          state_nxt = ST_WEX2;
        end
      end
      ST_WEX2: begin
        p_we      = 1'b1;
        p_waddr   = right_f;
        p_wdata   = {depth_f + 1'b1, (code_f << 1) | WW'(1)};
        n_nxt     = n_r - 1'b1;
        state_nxt = ST_WRD;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_RCLR;
      s_r         <= SW'(NUM_SYMBOLS - 1);
      status_r    <= STAT_OK;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      s_r         <= s_nxt;
      status_r    <= status_nxt;
      out_valid_r <= out_valid_nxt;
    end
    count_r    <= count_nxt;
    nodes_r    <= nodes_nxt;
    pos_r      <= pos_nxt;
    i_r        <= i_nxt;
    o_r        <= o_nxt;
    ins_r      <= ins_nxt;
    n_r        <= n_nxt;
    cur_w_r    <= cur_w_nxt;
    a_r        <= a_nxt;
    e_r        <= e_nxt;
    rd_sym_r   <= rd_sym_nxt;
    oor_r      <= oor_nxt;
    out_data_r <= out_data_nxt;
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// File: src/hc_ram.sv
module hc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: src/hc_alu.sv
module hc_alu
  import hcb_pkg::*;
(
  input  logic [WW-1:0] x,
  input  logic [WW-1:0] y,
  output alu_res_t      res
);

  // shared adder and magnitude compare
  always_comb begin
    res.sum = x + y;
    res.gt  = (x > y);
    res.lt  = (x < y);
  end

endmodule

// File: src/hcb_checker.sv
`include "huffman_code_builder_top_defines.svh"

module hcb_checker
  import hcb_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_ready,
  input in_word_t  in_data,
  input logic      out_valid,
  input logic      out_ready,
  input out_word_t out_data
);

  `HCB_ASSERT_ALWAYS(a_busy_after_reset, clk, !rst_n |=> !in_ready, "ready right after reset")
  `HCB_ASSERT(a_read_busy, clk, rst_n, (in_valid && in_ready && in_data.req_type != REQ_LOAD) |=> !in_ready, "read not held busy")
  `HCB_ASSERT(a_load_silent, clk, rst_n, (in_valid && in_ready && in_data.req_type == REQ_LOAD && !out_valid) |=> !out_valid, "load made a result")
  `HCB_ASSERT(a_out_hold, clk, rst_n, (out_valid && !out_ready) |=> (out_valid && $stable(out_data)), "stalled result changed")

endmodule

bind huffman_code_builder_top hcb_checker u_hcb_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
  .in_data(in_data), .out_valid(out_valid), .out_ready(out_ready),
  .out_data(out_data));
